FILE: src/urng_pkg.sv
// ----------------------------------------------------------------------------
// urng_pkg
// Shared types and constants of the ultrasonic ranger with occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

package urng_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_OCCUPIED_AT = 3'd0;
    localparam logic [2:0] REG_FREE_AT     = 3'd1;
    localparam logic [2:0] REG_TIMEOUT     = 3'd2;
    localparam logic [2:0] REG_PERIOD      = 3'd3;

    // Register reset values
    localparam logic [9:0]  RST_OCCUPIED_AT = 10'd13;
    localparam logic [9:0]  RST_FREE_AT     = 10'd18;
    localparam logic [15:0] RST_TIMEOUT     = 16'd30000;
    localparam logic [19:0] RST_PERIOD      = 20'd100000;

    localparam logic [9:0]  NO_ECHO_CM      = 10'd999;
    localparam logic [10:0] MAX_REAL_CM     = 11'd998;
    localparam logic [15:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [15:0] TRIG_HIGH_TICKS = 16'd10;
    localparam logic [19:0] PERIOD_MAX      = 20'hFFFFF;

    // x / 58 == (x * 72316) >> 22 for every 16-bit x (error 24 * x < 2^22)
    localparam logic [16:0] DIV58_MUL   = 17'd72316;
    localparam int          DIV58_SHIFT = 22;

    // Stage 1 -> stage 2: what one tick produced
    typedef struct packed {
        logic        trig;
        logic        done;
        logic        timed_out;
        logic [15:0] count;
    } t_meas;

    // Stage 2 -> stage 3: same with the count turned into centimeters
    typedef struct packed {
        logic        trig;
        logic        done;
        logic        timed_out;
        logic [10:0] quot;
    } t_quot;

endpackage

`default_nettype wire

FILE: src/urng_ctrl.sv
// ----------------------------------------------------------------------------
// urng_ctrl
// Trigger sequencer and echo timer, one tick per accepted transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_echo,
    input  wire  [15:0]         i_timeout,
    input  wire  [19:0]         i_period,
    output logic                o_valid,
    input  wire                 i_ready,
    output urng_pkg::t_meas     o_meas
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_RISE  = 3'd3,
        PH_PULSE = 3'd4
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [19:0]     r_period_count, n_period_count;
    logic [15:0]     r_step_count, n_step_count;
    logic            r_valid;
    urng_pkg::t_meas r_meas, n_meas;
    logic            w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_meas   = r_meas;

    always_comb begin
        n_phase        = r_phase;
        n_period_count = r_period_count;
        n_step_count   = r_step_count;
        n_meas         = '0;

        case (r_phase)
            PH_LOW, PH_HIGH, PH_RISE, PH_PULSE: n_phase = r_phase;
            default:                            n_phase = PH_IDLE;
        endcase

        if (n_phase == PH_IDLE && n_period_count >= i_period) begin
            n_phase        = PH_LOW;
            n_step_count   = '0;
            n_period_count = '0;
        end

        case (n_phase)
            PH_LOW: begin
                n_step_count = n_step_count + 16'd1;
                if (n_step_count >= urng_pkg::TRIG_LOW_TICKS) begin
                    n_phase      = PH_HIGH;
                    n_step_count = '0;
                end
            end
            PH_HIGH: begin
                n_meas.trig  = 1'b1;
                n_step_count = n_step_count + 16'd1;
                if (n_step_count >= urng_pkg::TRIG_HIGH_TICKS) begin
                    n_phase      = PH_RISE;
                    n_step_count = '0;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    n_phase      = PH_PULSE;
                    n_step_count = '0;
                end else if (n_step_count >= i_timeout) begin
                    n_meas.done      = 1'b1;
                    n_meas.timed_out = 1'b1;
                end else begin
                    n_step_count = n_step_count + 16'd1;
                end
            end
            PH_PULSE: begin
                if (!i_echo) begin
                    n_meas.done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // the rise tick already counts as a high tick
        if (n_phase == PH_PULSE && i_echo && !n_meas.done) begin
            if (n_step_count >= i_timeout) begin
                n_meas.done      = 1'b1;
                n_meas.timed_out = 1'b1;
            end else begin
                n_step_count = n_step_count + 16'd1;
            end
        end

        n_meas.count = n_step_count;

        if (n_meas.done) begin
            n_phase      = PH_IDLE;
            n_step_count = '0;
        end

        if (n_period_count < urng_pkg::PERIOD_MAX) begin
            n_period_count = n_period_count + 20'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_period_count <= '0;
            r_step_count   <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_period_count <= n_period_count;
                r_step_count   <= n_step_count;
                r_valid        <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_meas <= n_meas;
        end
    end

endmodule

`default_nettype wire

FILE: src/urng_div58.sv
// ----------------------------------------------------------------------------
// urng_div58
// Pulse width to centimeters: divide by 58 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_div58 (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  urng_pkg::t_meas     i_meas,
    output logic                o_valid,
    input  wire                 i_ready,
    output urng_pkg::t_quot     o_quot
);

    logic            r_valid;
    urng_pkg::t_quot r_quot, n_quot;
    logic [32:0]     w_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_quot  = r_quot;

    assign w_prod = 33'(i_meas.count) * 33'(urng_pkg::DIV58_MUL);

    always_comb begin
        n_quot.trig      = i_meas.trig;
        n_quot.done      = i_meas.done;
        n_quot.timed_out = i_meas.timed_out;
        n_quot.quot      = w_prod[urng_pkg::DIV58_SHIFT +: 11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_quot <= n_quot;
        end
    end

endmodule

`default_nettype wire

FILE: src/urng_occ.sv
// ----------------------------------------------------------------------------
// urng_occ
// Distance saturation, occupancy hysteresis and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module urng_occ (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  urng_pkg::t_quot     i_quot,
    input  wire  [9:0]          i_occupied_at,
    input  wire  [9:0]          i_free_at,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_data
);

    logic        r_valid;
    logic [9:0]  r_last_distance, n_last_distance;
    logic        r_occupied, n_occupied;
    logic [15:0] r_data, n_data;
    logic [9:0]  w_dist;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_dist = (i_quot.quot > urng_pkg::MAX_REAL_CM) ? urng_pkg::MAX_REAL_CM[9:0]
                                                           : i_quot.quot[9:0];

    always_comb begin
        n_last_distance = r_last_distance;
        n_occupied      = r_occupied;
        if (i_quot.done) begin
            if (i_quot.timed_out) begin
                n_last_distance = urng_pkg::NO_ECHO_CM;
            end else begin
                n_last_distance = w_dist;
                if (!r_occupied) begin
                    if (w_dist <= i_occupied_at) n_occupied = 1'b1;
                end else begin
                    if (w_dist >= i_free_at) n_occupied = 1'b0;
                end
            end
        end
        n_data = {2'b00, i_quot.timed_out, i_quot.done, n_occupied,
                  n_last_distance, i_quot.trig};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= 1'b0;
            r_last_distance <= urng_pkg::NO_ECHO_CM;
            r_occupied      <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid         <= 1'b1;
            r_last_distance <= n_last_distance;
            r_occupied      <= n_occupied;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/ultrasonic_ranger_occupancy.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_occupancy
// Ultrasonic ranger with trigger sequencing, echo timing and occupancy
// hysteresis; one input transaction per microsecond tick.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[0] echo_level
// m_axis    out  m_axis_tvalid/tready        tdata: trigger, distance, occupied,
//                                            done, no_echo (one per tick)
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// One tick is accepted every cycle unless m_axis stalls with all stages full;
// its result passes the sequencer, divide-by-58 multiply and result registers.
// Throughput is set by the sequencer, which closes its state loop per tick.
// Reset (synchronous, i_rst_n low) idles the sequencer, sets the distance to
// no-echo, clears occupancy and loads the register defaults.
// A stall on m_axis backs up the three stages; s_axis_tready drops only when
// all of them hold data.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranger_occupancy (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input tick stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] echo_level, [7:1] zero
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] trigger_level, [10:1] distance_cm,
                                        // [11] slot_occupied, [12] measurement_done,
                                        // [13] no_echo, [15:14] zero
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [19:0] i_cfg_data
);

    // configuration registers
    logic [9:0]  r_occupied_at;
    logic [9:0]  r_free_at;
    logic [15:0] r_timeout;
    logic [19:0] r_period;

    // stage handshakes
    logic            w_v1, w_r1, w_v2, w_r2;
    urng_pkg::t_meas w_meas;
    urng_pkg::t_quot w_quot;

    // writes complete at once; a write to an unknown index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied_at <= urng_pkg::RST_OCCUPIED_AT;
            r_free_at     <= urng_pkg::RST_FREE_AT;
            r_timeout     <= urng_pkg::RST_TIMEOUT;
            r_period      <= urng_pkg::RST_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                urng_pkg::REG_OCCUPIED_AT: r_occupied_at <= i_cfg_data[9:0];
                urng_pkg::REG_FREE_AT:     r_free_at     <= i_cfg_data[9:0];
                urng_pkg::REG_TIMEOUT:     r_timeout     <= i_cfg_data[15:0];
                urng_pkg::REG_PERIOD:      r_period      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage 1: trigger sequencer and echo timer
    urng_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_echo    (s_axis_tdata[0]),
        .i_timeout (r_timeout),
        .i_period  (r_period),
        .o_valid   (w_v1),
        .i_ready   (w_r1),
        .o_meas    (w_meas)
    );

    // stage 2: high-tick count to centimeters
    urng_div58 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_meas  (w_meas),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_quot  (w_quot)
    );

    // stage 3: latest distance, hysteresis, result register
    urng_occ u_occ (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_v2),
        .o_ready       (w_r2),
        .i_quot        (w_quot),
        .i_occupied_at (r_occupied_at),
        .i_free_at     (r_free_at),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: sim/tb_ultrasonic_ranger_occupancy.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_ranger_occupancy
// Self-checking bench for the ultrasonic ranger: a clocked driver sends echo
// ticks from a queue, a tick-level model predicts every result transaction,
// and a clocked monitor checks each result field by field under random stalls.
// ----------------------------------------------------------------------------

module tb_ultrasonic_ranger_occupancy;

    // Model constants
    localparam int unsigned LOW_TICKS   = 2;
    localparam int unsigned HIGH_TICKS  = 10;
    localparam int unsigned CM_DIV      = 58;
    localparam int unsigned NO_ECHO_VAL = 999;
    localparam int unsigned MAX_CM      = 998;
    localparam logic [19:0] PERIOD_SAT  = 20'hFFFFF;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_PULSE     = 3'd4
    } t_ranger_phase;

    typedef struct packed {
        logic       trig;
        logic [9:0] distance;
        logic       occupied;
        logic       done;
        logic       no_echo;
    } t_ranger_result;

    typedef struct packed {
        logic [2:0]  idx;
        logic [19:0] data;
    } t_reg_write;

    // DUT connections, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [0] echo_level, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [0] trigger, [10:1] distance, [11] occupied,
                                         // [12] done, [13] no_echo, [15:14] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = 3'd0;
    logic [19:0] i_cfg_data    = 20'd0;

    ultrasonic_ranger_occupancy DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Ranger model: register copies and sequencer state, reset values
    // ------------------------------------------------------------------------
    logic [9:0]    occ_at    = urng_pkg::RST_OCCUPIED_AT;
    logic [9:0]    free_at   = urng_pkg::RST_FREE_AT;
    logic [15:0]   echo_tmo  = urng_pkg::RST_TIMEOUT;
    logic [19:0]   period    = urng_pkg::RST_PERIOD;

    t_ranger_phase ph        = PH_IDLE;
    logic [19:0]   period_cnt = 20'd0;
    logic [15:0]   step_cnt  = 16'd0;
    logic [9:0]    last_dist = 10'd999;
    logic          occ_flag  = 1'b0;

    // Queues and bookkeeping
    bit             echo_q[$];       // ticks waiting to be sent
    t_ranger_result result_q[$];     // predicted results, oldest first
    t_reg_write     reg_wr_q[$];     // register writes waiting to be sent

    int  err_cnt       = 0;
    int  ticks_sent    = 0;
    int  meas_total    = 0;
    int  no_echo_total = 0;
    int  occ_toggles   = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    bit  no_gaps       = 1'b0;

    function automatic void apply_reg(input logic [2:0] idx, input logic [19:0] data);
        case (idx)
            urng_pkg::REG_OCCUPIED_AT: occ_at   = data[9:0];
            urng_pkg::REG_FREE_AT:     free_at  = data[9:0];
            urng_pkg::REG_TIMEOUT:     echo_tmo = data[15:0];
            urng_pkg::REG_PERIOD:      period   = data;
            default: ;       // indexes above the register map are dropped
        endcase
    endfunction

    // One microsecond tick through the sequencer
    function automatic t_ranger_result range_tick(input logic echo);
        t_ranger_result r;
        logic           done;
        logic           tmo;
        int unsigned    quot;
        r    = '0;
        done = 1'b0;
        tmo  = 1'b0;

        if (ph == PH_IDLE && period_cnt >= period) begin
            ph         = PH_TRIG_LOW;
            step_cnt   = 16'd0;
            period_cnt = 20'd0;
        end

        case (ph)
            PH_TRIG_LOW: begin
                step_cnt = step_cnt + 16'd1;
                if (step_cnt >= LOW_TICKS) begin
                    ph       = PH_TRIG_HIGH;
                    step_cnt = 16'd0;
                end
            end
            PH_TRIG_HIGH: begin
                r.trig   = 1'b1;
                step_cnt = step_cnt + 16'd1;
                if (step_cnt >= HIGH_TICKS) begin
                    ph       = PH_WAIT_RISE;
                    step_cnt = 16'd0;
                end
            end
            PH_WAIT_RISE: begin
                if (echo) begin
                    ph       = PH_PULSE;
                    step_cnt = 16'd0;
                end else if (step_cnt >= echo_tmo) begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end else begin
                    step_cnt = step_cnt + 16'd1;
                end
            end
            PH_PULSE: begin
                if (!echo) done = 1'b1;
            end
            default: ;
        endcase

        // the rise tick already counts as high
        if (ph == PH_PULSE && echo && !done) begin
            if (step_cnt >= echo_tmo) begin
                done = 1'b1;
                tmo  = 1'b1;
            end else begin
                step_cnt = step_cnt + 16'd1;
            end
        end

        if (done) begin
            meas_total++;
            if (tmo) begin
                last_dist = 10'(NO_ECHO_VAL);
                no_echo_total++;
            end else begin
                quot = step_cnt / CM_DIV;
                if (quot > MAX_CM) quot = MAX_CM;
                last_dist = quot[9:0];
                if (!occ_flag) begin
                    if (quot <= occ_at) begin
                        occ_flag = 1'b1;
                        occ_toggles++;
                    end
                end else if (quot >= free_at) begin
                    occ_flag = 1'b0;
                    occ_toggles++;
                end
            end
            ph       = PH_IDLE;
            step_cnt = 16'd0;
        end

        if (period_cnt < PERIOD_SAT) period_cnt = period_cnt + 20'd1;

        r.distance = last_dist;
        r.occupied = occ_flag;
        r.done     = done;
        r.no_echo  = tmo;
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Tick driver: model runs on every accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.push_back(range_tick(s_axis_tdata[0]));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (echo_q.size() > 0) begin
                    s_axis_tdata  <= {7'd0, echo_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register write driver: model copy updated on each accepted write
    always @(posedge i_clk) begin
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_wr_q.size() > 0) begin
                    w = reg_wr_q.pop_front();
                    i_cfg_index <= w.idx;
                    i_cfg_data  <= w.data;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random backpressure
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [9:0] exp_v,
                               input logic [9:0] act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_ranger_result e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result transaction, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    e = result_q.pop_front();
                    check_field("trigger_level",    e.trig,     m_axis_tdata[0]);
                    check_field("distance_cm",      e.distance, m_axis_tdata[10:1]);
                    check_field("slot_occupied",    e.occupied, m_axis_tdata[11]);
                    check_field("measurement_done", e.done,     m_axis_tdata[12]);
                    check_field("no_echo",          e.no_echo,  m_axis_tdata[13]);
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left    <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus; all waits on the falling edge so queue state is settled
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        while (echo_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);    // pipeline depth is three
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        t_reg_write w;
        w.idx  = idx;
        w.data = data;
        reg_wr_q.push_back(w);
    endtask

    task automatic program_regs(input logic [19:0] occ, input logic [19:0] fre,
                                input logic [19:0] tmo, input logic [19:0] per);
        wait_idle();
        write_reg(urng_pkg::REG_OCCUPIED_AT, occ);
        write_reg(urng_pkg::REG_FREE_AT, fre);
        write_reg(urng_pkg::REG_TIMEOUT, tmo);
        write_reg(urng_pkg::REG_PERIOD, per);
        while (reg_wr_q.size() != 0 || i_cfg_valid) @(negedge i_clk);
    endtask

    task automatic push_level(input bit lvl, input int n);
        repeat (n) echo_q.push_back(lvl);
    endtask

    // 12 trigger ticks fit in pre, then the echo pulse and its falling tick
    task automatic push_pulse(input int pre, input int width);
        push_level(1'b0, pre);
        push_level(1'b1, width);
        push_level(1'b0, 1);
    endtask

    initial begin
        int  pushed;
        int  r;
        bit  paused;
        logic [19:0] v_occ, v_free, v_tmo, v_per;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: long period, so the block just idles at no-echo
        push_level(1'b0, 6);
        push_level(1'b1, 3);
        push_level(1'b0, 3);

        // Tight thresholds, no period, longest timeout
        program_regs(20'd0, 20'd1, 20'd65535, 20'd0);
        push_pulse(14, 4);               // 0 cm sets occupancy
        push_pulse(14, 3);               // 0 cm below the free threshold, no change
        push_pulse(14, 58);              // 1 cm at the free threshold, clears
        // echo activity during the trigger is ignored
        push_level(1'b0, 3);
        push_level(1'b1, 6);
        push_pulse(5, 1);

        // Rise and fall timeouts
        program_regs(20'd0, 20'd1, 20'd5, 20'd0);
        push_level(1'b0, 20);
        push_pulse(14, 8);

        // Zero timeout: either wait gives up at once
        program_regs(20'd0, 20'd1, 20'd0, 20'd0);
        push_level(1'b0, 14);
        push_level(1'b1, 14);

        // Inverted thresholds: every measurement flips occupancy
        program_regs(20'd500, 20'd0, 20'd65535, 20'd0);
        push_pulse(14, 2);
        push_pulse(14, 2);

        // Writes beyond the register map change nothing
        wait_idle();
        write_reg(3'd4, 20'hFFFFF);
        write_reg(3'd5, 20'hFFFFF);
        write_reg(3'd6, 20'hFFFFF);
        write_reg(3'd7, 20'hFFFFF);
        while (reg_wr_q.size() != 0 || i_cfg_valid) @(negedge i_clk);
        push_pulse(14, 8);

        // Upper data bits dropped; widest values of every register
        program_regs(20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hFFFFF);
        push_level(1'b1, 5);
        program_regs(20'h3FF, 20'h003FF, 20'h0FFFF, 20'd1000000);
        push_level(1'b0, 5);

        // Smallest nominal period: starts 100 ticks apart
        program_regs(20'd1023, 20'd0, 20'd400, 20'd100);
        push_pulse(14, 5);
        push_level(1'b0, 82);

        // Random phases
        for (int p = 0; p < 2; p++) begin
            r      = $urandom_range(0, 3);
            v_occ  = (r != 0) ? 20'($urandom_range(0, 4)) : 20'($urandom_range(0, 1023));
            r      = $urandom_range(0, 3);
            v_free = (r != 0) ? 20'($urandom_range(0, 4)) : 20'($urandom_range(0, 1023));
            v_occ  = v_occ  | (20'($urandom_range(0, 1023)) << 10);
            v_free = v_free | (20'($urandom_range(0, 1023)) << 10);
            r = $urandom_range(0, 9);
            if (r == 0)      v_tmo = 20'd0;
            else if (r == 1) v_tmo = 20'd65535;
            else             v_tmo = 20'($urandom_range(1, 60));
            v_tmo = v_tmo | (20'($urandom_range(0, 15)) << 16);
            v_per = ($urandom_range(0, 4) < 2) ? 20'd0 : 20'($urandom_range(1, 80));
            program_regs(v_occ, v_free, v_tmo, v_per);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(3'($urandom_range(4, 7)), 20'($urandom));
                while (reg_wr_q.size() != 0 || i_cfg_valid) @(negedge i_clk);
            end

            no_gaps = (p == 0);
            pushed  = 0;
            paused  = 1'b0;
            while (pushed < 15) begin
                while (echo_q.size() > 32) @(negedge i_clk);
                if ($urandom_range(0, 4) != 0) begin
                    // well-formed: quiet stretch, then one echo pulse
                    r = $urandom_range(0, 8);
                    push_level(1'b0, r);
                    pushed += r;
                    r = $urandom_range(1, 70);
                    push_level(1'b1, r);
                    pushed += r;
                end else begin
                    r = $urandom_range(1, 10);
                    repeat (r) echo_q.push_back(1'($urandom));
                    pushed += r;
                end
                // hold the sender until every result is back, once
                if (p == 1 && pushed > 5 && !paused) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            no_gaps = 1'b0;
        end

        wait_idle();
        repeat (10) @(negedge i_clk);

        $display("Run covered %0d ticks, %0d measurements (%0d without echo),",
                 ticks_sent, meas_total, no_echo_total);
        $display("%0d occupancy changes and %0d failed checks.", occ_toggles, err_cnt);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("** ultrasonic_ranger_occupancy: PASSED **");
        end else begin
            $display("** ultrasonic_ranger_occupancy: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #250_000_000;
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("** ultrasonic_ranger_occupancy: FAILED **");
        $finish;
    end

endmodule
